// ===== design/dad_pkg.sv =====
// Shared types, limits and month table for the date adder.
`timescale 1ns / 1ps

package dad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int R400_W  = 9;

    typedef logic [YEAR_W-1:0]  t_year;
    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [R400_W-1:0]  t_r400;

    localparam t_year  YEAR_MIN  = t_year'(1);
    localparam t_year  YEAR_MAX  = t_year'(9999);
    localparam t_year  CYCLE_400 = t_year'(400);
    localparam t_r400  R400_LAST = t_r400'(399);
    localparam t_month MONTH_JAN = t_month'(1);
    localparam t_month MONTH_FEB = t_month'(2);
    localparam t_month MONTH_DEC = t_month'(12);
    localparam t_day   DAY_FIRST = t_day'(1);
    localparam t_day   DAY_LAST  = t_day'(31);

    // Common-year month lengths; anything outside 1..12 reads as 31.
    function automatic t_day month_len_base(input t_month m);
        t_day len;
        unique case (m)
            4'd2:                      len = t_day'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   len = t_day'(30);
            default:                   len = t_day'(31);
        endcase
        return len;
    endfunction

endpackage

// ===== design/date_add_days.sv =====
// Top level: date plus signed day offset, stepped one month per cycle.
`timescale 1ns / 1ps
// Usage:
//   Drive i_start_year/month/day and i_day_offset and raise start while busy
//   is low; the item transfers at that clock edge and busy goes high.
//   The block first reduces the year mod 400 (one subtraction of 400 per
//   cycle), then walks the day count one month per cycle through a single
//   shared add/compare unit and month-length lookup.
//   One item is in flight at a time; busy stays high until the result.
//   The result appears on o_result_* with o_done high for exactly one cycle,
//   in the same cycle busy drops; the receiver must take it then.
//   Out-of-range input years/months are clamped to 1..9999 and 1..12.
//   A result year past 9999 gives 9999-12-31, before 1 gives 0001-01-01,
//   both with o_out_of_range set.
//   Synchronous active-low reset returns the block to idle with o_done low.
//   Any item in flight at reset is dropped.

module date_add_days #(
    parameter int OFFSET_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [13:0]                 i_start_year,
    input  logic [3:0]                  i_start_month,
    input  logic [4:0]                  i_start_day,
    input  logic signed [OFFSET_WIDTH-1:0] i_day_offset,
    output logic                        o_done,
    output logic [13:0]                 o_result_year,
    output logic [3:0]                  o_result_month,
    output logic [4:0]                  o_result_day,
    output logic                        o_out_of_range
);

    localparam int DW = OFFSET_WIDTH + 2;

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_FWD, S_BWD} t_state;

    t_state               r_state, n_state;
    dad_pkg::t_year       r_year, n_year;
    dad_pkg::t_year       r_rem, n_rem;     // year mod 400 once S_PREP ends
    dad_pkg::t_month      r_month, n_month;
    logic signed [DW-1:0] r_day, n_day;
    logic                 r_done, n_done;
    logic                 r_oor, n_oor;

    dad_pkg::t_month      prev_month;
    dad_pkg::t_month      len_month;
    dad_pkg::t_day        len;
    logic signed [DW-1:0] len_ext;
    logic signed [DW-1:0] sum;
    dad_pkg::t_r400       r400;
    dad_pkg::t_r400       r400_inc;
    dad_pkg::t_r400       r400_dec;
    dad_pkg::t_year       yr_in;
    dad_pkg::t_month      mo_in;

    assign r400       = r_rem[dad_pkg::R400_W-1:0];
    assign r400_inc   = (r400 == dad_pkg::R400_LAST) ? '0 : r400 + dad_pkg::t_r400'(1);
    assign r400_dec   = (r400 == '0) ? dad_pkg::R400_LAST : r400 - dad_pkg::t_r400'(1);
    assign prev_month = (r_month == dad_pkg::MONTH_JAN) ? dad_pkg::MONTH_DEC
                                                        : r_month - dad_pkg::t_month'(1);
    // Going back, the month borrowed from is the previous one. December is 31
    // days in any year, so the year wrap does not affect the lookup.
    assign len_month  = (r_state == S_BWD) ? prev_month : r_month;

    dad_mlen u_mlen (
        .i_month (len_month),
        .i_r400  (r400),
        .o_len   (len)
    );

    // Shared adder: subtract the month going forward, add it going back.
    assign len_ext = DW'(signed'({1'b0, len}));
    assign sum     = (r_state == S_BWD) ? r_day + len_ext : r_day - len_ext;

    always_comb begin
        yr_in = i_start_year;
        if (i_start_year < dad_pkg::YEAR_MIN) yr_in = dad_pkg::YEAR_MIN;
        if (i_start_year > dad_pkg::YEAR_MAX) yr_in = dad_pkg::YEAR_MAX;
        mo_in = i_start_month;
        if (i_start_month < dad_pkg::MONTH_JAN) mo_in = dad_pkg::MONTH_JAN;
        if (i_start_month > dad_pkg::MONTH_DEC) mo_in = dad_pkg::MONTH_DEC;
    end

    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_rem   = r_rem;
        n_month = r_month;
        n_day   = r_day;
        n_done  = 1'b0;
        n_oor   = r_oor;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_year  = yr_in;
                    n_rem   = yr_in;
                    n_month = mo_in;
                    n_day   = DW'(signed'({1'b0, i_start_day})) + DW'(i_day_offset);
                    n_oor   = 1'b0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_rem >= dad_pkg::CYCLE_400) begin
                    n_rem = r_rem - dad_pkg::CYCLE_400;
                end else begin
                    n_state = S_FWD;
                end
            end
            S_FWD: begin
                if (sum > 0) begin
                    // day still past the end of this month
                    n_day = sum;
                    if (r_month == dad_pkg::MONTH_DEC) begin
                        n_month = dad_pkg::MONTH_JAN;
                        if (r_year == dad_pkg::YEAR_MAX) begin
                            n_oor   = 1'b1;
                            n_month = dad_pkg::MONTH_DEC;
                            n_day   = DW'(signed'({1'b0, dad_pkg::DAY_LAST}));
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_year = r_year + dad_pkg::t_year'(1);
                            n_rem  = dad_pkg::t_year'(r400_inc);
                        end
                    end else begin
                        n_month = r_month + dad_pkg::t_month'(1);
                    end
                end else if (r_day > 0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_BWD;
                end
            end
            S_BWD: begin
                if (r_day <= 0) begin
                    n_day   = sum;
                    n_month = prev_month;
                    if (r_month == dad_pkg::MONTH_JAN) begin
                        if (r_year == dad_pkg::YEAR_MIN) begin
                            n_oor   = 1'b1;
                            n_month = dad_pkg::MONTH_JAN;
                            n_day   = DW'(signed'({1'b0, dad_pkg::DAY_FIRST}));
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_year = r_year - dad_pkg::t_year'(1);
                            n_rem  = dad_pkg::t_year'(r400_dec);
                        end
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_oor   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_oor   <= n_oor;
        end
        r_year  <= n_year;
        r_rem   <= n_rem;
        r_month <= n_month;
        r_day   <= n_day;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_year  = r_year;
    assign o_result_month = r_month;
    assign o_result_day   = r_day[dad_pkg::DAY_W-1:0];
    assign o_out_of_range = r_oor;

endmodule

// ===== design/dad_mlen.sv =====
// Month length unit: table lookup plus the 4/100/400 leap-year rule.
`timescale 1ns / 1ps

module dad_mlen (
    input  dad_pkg::t_month i_month,
    input  dad_pkg::t_r400  i_r400,    // year mod 400
    output dad_pkg::t_day   o_len
);

    logic cent;
    logic leap;

    // year mod 4 equals (year mod 400) mod 4
    assign cent = (i_r400 == dad_pkg::t_r400'(0))   || (i_r400 == dad_pkg::t_r400'(100)) ||
                  (i_r400 == dad_pkg::t_r400'(200)) || (i_r400 == dad_pkg::t_r400'(300));
    assign leap = (i_r400 == dad_pkg::t_r400'(0)) || (!cent && (i_r400[1:0] == 2'b00));

    always_comb begin
        if (i_month == dad_pkg::MONTH_FEB && leap) begin
            o_len = dad_pkg::t_day'(29);
        end else begin
            o_len = dad_pkg::month_len_base(i_month);
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for date_add_days: directed and random date requests.
`timescale 1ns / 1ps

module tb_top;

    localparam int OFFSET_W   = 20;
    localparam int QUIET_MAX  = 100000;  // largest offset walks about 17300 months
    localparam int TAIL_WAIT  = 64;
    localparam int RAND_COUNT = 76;
    localparam int COMMON_DAYS [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef logic signed [OFFSET_W-1:0] t_offset;

    typedef struct {
        dad_pkg::t_year  year;
        dad_pkg::t_month month;
        dad_pkg::t_day   day;
        t_offset         offset;
        int              gap;
        bit              drain;
    } t_date_req;

    typedef struct {
        dad_pkg::t_year  year;
        dad_pkg::t_month month;
        dad_pkg::t_day   day;
        logic            oor;
    } t_date_res;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            start          = 1'b0;
    dad_pkg::t_year  i_start_year   = '0;
    dad_pkg::t_month i_start_month  = '0;
    dad_pkg::t_day   i_start_day    = '0;
    t_offset         i_day_offset   = '0;
    logic            busy;
    logic            o_done;
    dad_pkg::t_year  o_result_year;
    dad_pkg::t_month o_result_month;
    dad_pkg::t_day   o_result_day;
    logic            o_out_of_range;

    t_date_req pending_requests[$];
    t_date_res expected_dates[$];
    t_date_req cur_req;
    int        gap_left = 0;
    int        quiet_cycles = 0;
    int        mismatches = 0;

    date_add_days #(
        .OFFSET_WIDTH(OFFSET_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_day_offset  (i_day_offset),
        .o_done        (o_done),
        .o_result_year (o_result_year),
        .o_result_month(o_result_month),
        .o_result_day  (o_result_day),
        .o_out_of_range(o_out_of_range)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint month_days(longint y, longint m);
        if (m == int'(dad_pkg::MONTH_FEB) &&
            ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
            return 29;
        return COMMON_DAYS[m];
    endfunction

    // Clamp the start date, add the offset to the day, then normalize month by month.
    function automatic t_date_res calendar_advance(t_date_req r);
        longint    y;
        longint    m;
        longint    d;
        bit        sat;
        t_date_res res;
        y   = r.year;
        m   = r.month;
        d   = r.day;
        sat = 1'b0;
        if (y < int'(dad_pkg::YEAR_MIN)) y = int'(dad_pkg::YEAR_MIN);
        if (y > int'(dad_pkg::YEAR_MAX)) y = int'(dad_pkg::YEAR_MAX);
        if (m < int'(dad_pkg::MONTH_JAN)) m = int'(dad_pkg::MONTH_JAN);
        if (m > int'(dad_pkg::MONTH_DEC)) m = int'(dad_pkg::MONTH_DEC);
        d = d + longint'(r.offset);
        while (!sat && d > month_days(y, m)) begin
            d = d - month_days(y, m);
            m++;
            if (m > int'(dad_pkg::MONTH_DEC)) begin
                m = int'(dad_pkg::MONTH_JAN);
                y++;
                if (y > int'(dad_pkg::YEAR_MAX)) begin
                    sat = 1'b1;
                    y   = int'(dad_pkg::YEAR_MAX);
                    m   = int'(dad_pkg::MONTH_DEC);
                    d   = int'(dad_pkg::DAY_LAST);
                end
            end
        end
        while (!sat && d <= 0) begin
            m--;
            if (m < int'(dad_pkg::MONTH_JAN)) begin
                m = int'(dad_pkg::MONTH_DEC);
                y--;
                if (y < int'(dad_pkg::YEAR_MIN)) begin
                    sat = 1'b1;
                    y   = int'(dad_pkg::YEAR_MIN);
                    m   = int'(dad_pkg::MONTH_JAN);
                    d   = int'(dad_pkg::DAY_FIRST);
                    break;
                end
            end
            d = d + month_days(y, m);
        end
        res.year  = dad_pkg::t_year'(y);
        res.month = dad_pkg::t_month'(m);
        res.day   = dad_pkg::t_day'(d);
        res.oor   = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_request(input int y, input int m, input int d, input int off,
                                input bit drain, input bit no_gap);
        t_date_req r;
        r.year   = dad_pkg::t_year'(y);
        r.month  = dad_pkg::t_month'(m);
        r.day    = dad_pkg::t_day'(d);
        r.offset = t_offset'(off);
        r.gap    = no_gap ? 0 : int'($urandom_range(0, 17));
        r.drain  = drain;
        pending_requests.push_back(r);
    endtask

    // Driver: gaps count only while the block is idle, so they land after results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            expected_dates.push_back(calendar_advance(cur_req));
            if (pending_requests.size() != 0 && pending_requests[0].gap == 0 &&
                !pending_requests[0].drain) begin
                cur_req        = pending_requests.pop_front();
                i_start_year  <= cur_req.year;
                i_start_month <= cur_req.month;
                i_start_day   <= cur_req.day;
                i_day_offset  <= cur_req.offset;
            end else begin
                start <= 1'b0;
                if (pending_requests.size() != 0)
                    gap_left <= pending_requests[0].gap;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                if (!busy)
                    gap_left <= gap_left - 1;
            end else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].drain || (!busy && !o_done))) begin
                cur_req        = pending_requests.pop_front();
                i_start_year  <= cur_req.year;
                i_start_month <= cur_req.month;
                i_start_day   <= cur_req.day;
                i_day_offset  <= cur_req.offset;
                start         <= 1'b1;
            end
        end
    end

    // Monitor: every strobe is a result transfer.
    always @(posedge i_clk) begin
        t_date_res want;
        if (i_rst_n && o_done) begin
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("result %0d-%0d-%0d oor=%0b with no request open",
                                          o_result_year, o_result_month, o_result_day,
                                          o_out_of_range));
            end else begin
                want = expected_dates.pop_front();
                if (o_result_year !== want.year || o_result_month !== want.month ||
                    o_result_day !== want.day || o_out_of_range !== want.oor)
                    report_mismatch($sformatf(
                        "got %0d-%0d-%0d oor=%0b, expected %0d-%0d-%0d oor=%0b",
                        o_result_year, o_result_month, o_result_day, o_out_of_range,
                        want.year, want.month, want.day, want.oor));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("date_add_days verification failed");
                $finish;
            end
        end
    end

    initial begin
        int y;
        int m;
        int d;
        int off;
        int kind;

        // month, leap and year boundaries
        push_request(2024, 1, 31, 1, 1'b0, 1'b1);
        push_request(2024, 2, 28, 1, 1'b0, 1'b1);
        push_request(2023, 2, 28, 1, 1'b0, 1'b0);
        push_request(1900, 2, 28, 1, 1'b0, 1'b0);
        push_request(2000, 2, 28, 1, 1'b0, 1'b0);
        push_request(2000, 3, 1, -1, 1'b1, 1'b0);
        push_request(2024, 1, 1, -1, 1'b0, 1'b0);
        push_request(2023, 12, 31, 1, 1'b0, 1'b0);
        push_request(1987, 6, 15, 0, 1'b0, 1'b1);
        // extreme offsets
        push_request(1, 1, 1, (1 << (OFFSET_W - 1)) - 1, 1'b0, 1'b0);
        push_request(9999, 12, 31, -(1 << (OFFSET_W - 1)), 1'b0, 1'b0);
        // saturation both ways
        push_request(9999, 12, 31, 0, 1'b0, 1'b0);
        push_request(9999, 12, 31, 1, 1'b0, 1'b1);
        push_request(1, 1, 1, -1, 1'b0, 1'b0);
        push_request(9000, 1, 1, (1 << (OFFSET_W - 1)) - 1, 1'b0, 1'b0);
        push_request(1000, 1, 1, -(1 << (OFFSET_W - 1)), 1'b0, 1'b0);
        // clamped start year and month
        push_request(0, 5, 10, 0, 1'b0, 1'b0);
        push_request(16383, 7, 4, 3, 1'b0, 1'b0);
        push_request(2010, 0, 20, 0, 1'b0, 1'b0);
        push_request(2010, 15, 20, 15, 1'b0, 1'b0);
        // start day not valid for its month
        push_request(2024, 3, 0, 0, 1'b0, 1'b0);
        push_request(2021, 4, 31, 0, 1'b0, 1'b0);
        push_request(2023, 2, 31, 0, 1'b0, 1'b0);
        push_request(1, 1, 0, 0, 1'b0, 1'b0);

        for (int i = 0; i < RAND_COUNT; i++) begin
            y = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 16383))
                                             : int'($urandom_range(1, 9999));
            m = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 15))
                                            : int'($urandom_range(1, 12));
            d = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 31))
                                            : int'($urandom_range(1, 28));
            kind = int'($urandom_range(0, 99));
            // most offsets stay small since latency grows with months crossed
            if (kind < 40) begin
                off = int'($urandom_range(0, 120)) - 60;
            end else if (kind < 75) begin
                off = int'($urandom_range(0, 10000)) - 5000;
            end else if (kind < 85) begin
                off = int'($urandom_range(0, 200000)) - 100000;
            end else if (kind < 90) begin
                off = int'($urandom());
            end else if (kind < 95) begin
                y   = int'($urandom_range(9990, 9999));
                off = int'($urandom_range(0, 5000));
            end else begin
                y   = int'($urandom_range(1, 10));
                off = -int'($urandom_range(0, 5000));
            end
            push_request(y, m, d, off, (i % 17) == 3, ((i / 10) % 3) == 1);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start || expected_dates.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);

        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

        if (mismatches == 0)
            $display("date_add_days verification clean");
        else
            $display("date_add_days verification failed");
        $finish;
    end

endmodule
